[rtl/core/cddir_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cddir_pkg
// Shared widths, codes and types of the cache tag directory.
// ----------------------------------------------------------------------------
package cddir_pkg;

	localparam int IW     = 14;
	localparam int EPO_W  = 15;
	localparam int BS_W   = 9;
	localparam int NS_W   = 7;
	localparam int RK_W   = 6;
	localparam int DV_W   = 17;
	localparam int SLOT_W = 8;
	localparam int SEEN_W = 16;
	localparam int CNT_W  = 32;
	localparam int REG_W  = 2;
	localparam int PH_W   = 3;

	localparam logic [1:0] OUT_CACHE_HIT = 2'd0;
	localparam logic [1:0] OUT_LOCAL_HIT = 2'd1;
	localparam logic [1:0] OUT_MISS      = 2'd2;

	localparam logic [REG_W-1:0] REG_EPO   = 2'd0;
	localparam logic [REG_W-1:0] REG_BS    = 2'd1;
	localparam logic [REG_W-1:0] REG_SLOTS = 2'd2;
	localparam logic [REG_W-1:0] REG_RANK  = 2'd3;

	typedef struct packed {
		logic            start;
		logic [IW-1:0]   dividend;
		logic [DV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic            done;
		logic [IW-1:0]   quot;
		logic [DV_W-1:0] rem;
	} div_rsp_t;

	typedef struct packed {
		logic [IW-1:0]     owner;
		logic [IW-1:0]     in_owner;
		logic [IW-1:0]     blk_start;
		logic [IW-1:0]     tag;
		logic [IW-1:0]     pos;
		logic [SLOT_W-1:0] slot;
		logic [SEEN_W-1:0] seen_idx;
		logic              owned_here;
	} item_t;

	typedef struct packed {
		logic clearing;
	} back_stat_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (&v) ? v : v + CNT_W'(1);
	endfunction

endpackage

[rtl/core/distributed_direct_mapped_cache_dir.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distributed_direct_mapped_cache_dir
// Direct mapped cache tag directory for a block distributed array.
// ----------------------------------------------------------------------------
// Each request is split by a shared one-bit-per-cycle divider into four
// divisions (owner, tag, block start, slot), and the front end takes no new
// request until it has handed the last one to the queue and is back in idle.
// The back end first reads the stores and then evaluates and updates them.
// A two-entry queue separates them, and a finished result waits in an output
// register while the next request is already accepted; a full queue holds the
// front end and an unread result holds the back end. After reset the fetch map
// is cleared one entry per cycle, with full held high.
module distributed_direct_mapped_cache_dir #(
	parameter int ARRAY_SIZE = 16384,
	parameter int MAX_SLOTS  = 64,
	parameter int MAX_BLOCK  = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [cddir_pkg::IW-1:0]      element_index,
	output logic                          empty,
	input  logic                          pop,
	output logic [1:0]                    outcome,
	output logic [cddir_pkg::IW-1:0]      cache_position,
	output logic [cddir_pkg::IW-1:0]      owner_number,
	output logic [cddir_pkg::IW-1:0]      index_in_owner,
	output logic [cddir_pkg::IW-1:0]      owner_block_start,
	output logic [cddir_pkg::IW-1:0]      block_tag,
	output logic                          evicted,
	output logic                          fetched_before,
	output logic [cddir_pkg::CNT_W-1:0]   hit_total,
	output logic [cddir_pkg::CNT_W-1:0]   miss_total,
	output logic [cddir_pkg::CNT_W-1:0]   eviction_total,
	output logic [cddir_pkg::CNT_W-1:0]   refetch_total,
	input  logic                          wr_en,
	input  logic [cddir_pkg::REG_W-1:0]   wr_index,
	input  logic [cddir_pkg::EPO_W-1:0]   wr_data
);
	logic [cddir_pkg::EPO_W-1:0]  epo_q;
	logic [cddir_pkg::BS_W-1:0]   bs_q;
	logic [cddir_pkg::NS_W-1:0]   ns_q;
	logic [cddir_pkg::RK_W-1:0]   rank_q;
	logic                         front_busy, q_push, q_pop, q_full, q_empty;
	cddir_pkg::item_t             push_item;
	cddir_pkg::item_t             fifo_q [2];
	logic                         wp_q, rp_q;
	logic [1:0]                   cnt_q;
	cddir_pkg::back_stat_t        bstat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epo_q  <= cddir_pkg::EPO_W'(256);
			bs_q   <= cddir_pkg::BS_W'(5);
			ns_q   <= cddir_pkg::NS_W'(10);
			rank_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				cddir_pkg::REG_EPO:   epo_q  <= wr_data;
				cddir_pkg::REG_BS:    bs_q   <= wr_data[cddir_pkg::BS_W-1:0];
				cddir_pkg::REG_SLOTS: ns_q   <= wr_data[cddir_pkg::NS_W-1:0];
				cddir_pkg::REG_RANK:  rank_q <= wr_data[cddir_pkg::RK_W-1:0];
				default: ;
			endcase
		end
	end

	assign full = front_busy || bstat.clearing;

	cddir_front #(
		.ARRAY_SIZE (ARRAY_SIZE),
		.MAX_SLOTS  (MAX_SLOTS),
		.MAX_BLOCK  (MAX_BLOCK)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push && !bstat.clearing),
		.element_index (element_index),
		.busy          (front_busy),
		.epo_reg       (epo_q),
		.bs_reg        (bs_q),
		.ns_reg        (ns_q),
		.rank_reg      (rank_q),
		.q_push        (q_push),
		.q_item        (push_item),
		.q_full        (q_full)
	);

	assign q_full  = (cnt_q == 2'd2);
	assign q_empty = (cnt_q == 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (q_push)
				wp_q <= !wp_q;
			if (q_pop)
				rp_q <= !rp_q;
			if (q_push && !q_pop)
				cnt_q <= cnt_q + 2'd1;
			else if (q_pop && !q_push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_push)
			fifo_q[wp_q] <= push_item;
	end

	cddir_back #(
		.ARRAY_SIZE (ARRAY_SIZE),
		.MAX_SLOTS  (MAX_SLOTS)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.q_empty           (q_empty),
		.q_item            (fifo_q[rp_q]),
		.q_pop             (q_pop),
		.stat              (bstat),
		.pop               (pop),
		.empty             (empty),
		.outcome           (outcome),
		.cache_position    (cache_position),
		.owner_number      (owner_number),
		.index_in_owner    (index_in_owner),
		.owner_block_start (owner_block_start),
		.block_tag         (block_tag),
		.evicted           (evicted),
		.fetched_before    (fetched_before),
		.hit_total         (hit_total),
		.miss_total        (miss_total),
		.eviction_total    (eviction_total),
		.refetch_total     (refetch_total)
	);

endmodule

[rtl/core/cddir_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cddir_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cddir_div (
	input  logic               clk,
	input  logic               arst_n,
	input  cddir_pkg::div_req_t req,
	output cddir_pkg::div_rsp_t rsp
);
	localparam int CW = $clog2(cddir_pkg::IW + 1);

	logic                        busy_q;
	logic                        done_q;
	logic [CW-1:0]               cnt_q;
	logic [cddir_pkg::IW-1:0]    quot_q;
	logic [cddir_pkg::DV_W-1:0]  rem_q;
	logic [cddir_pkg::DV_W-1:0]  dvs_q;
	logic [cddir_pkg::DV_W-1:0]  trial;

	// The remainder stays below the divisor, so its top bit is always clear.
	assign trial = {rem_q[cddir_pkg::DV_W-2:0], quot_q[cddir_pkg::IW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(cddir_pkg::IW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quot_q <= req.dividend;
			rem_q  <= '0;
			dvs_q  <= req.divisor;
		end else if (busy_q) begin
			if (trial >= dvs_q) begin
				rem_q  <= trial - dvs_q;
				quot_q <= {quot_q[cddir_pkg::IW-2:0], 1'b1};
			end else begin
				rem_q  <= trial;
				quot_q <= {quot_q[cddir_pkg::IW-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;
	assign rsp.rem  = rem_q;

endmodule

[rtl/core/cddir_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cddir_front
// Accepts an index and splits it into owner, tag, slot and positions.
// ----------------------------------------------------------------------------
module cddir_front #(
	parameter int ARRAY_SIZE = 16384,
	parameter int MAX_SLOTS  = 64,
	parameter int MAX_BLOCK  = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  logic [cddir_pkg::IW-1:0]      element_index,
	output logic                          busy,
	input  logic [cddir_pkg::EPO_W-1:0]   epo_reg,
	input  logic [cddir_pkg::BS_W-1:0]    bs_reg,
	input  logic [cddir_pkg::NS_W-1:0]    ns_reg,
	input  logic [cddir_pkg::RK_W-1:0]    rank_reg,
	output logic                          q_push,
	output cddir_pkg::item_t              q_item,
	input  logic                          q_full
);
	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_DIV  = 3'b010,
		F_PUSH = 3'b100
	} fstate_t;

	localparam logic [cddir_pkg::PH_W-1:0] PH_OWN  = 3'd0;
	localparam logic [cddir_pkg::PH_W-1:0] PH_TAG  = 3'd1;
	localparam logic [cddir_pkg::PH_W-1:0] PH_BLK  = 3'd2;
	localparam logic [cddir_pkg::PH_W-1:0] PH_SLOT = 3'd3;

	fstate_t                         state_q;
	logic [cddir_pkg::PH_W-1:0]      phase_q;
	logic                            start_q;
	logic [cddir_pkg::IW-1:0]        idx_q, owner_q, in_owner_q, tag_q;
	logic [cddir_pkg::BS_W-1:0]      offset_q, rblk_q;
	logic [cddir_pkg::SLOT_W-1:0]    slot_q;
	logic [cddir_pkg::DV_W-1:0]      epo, bs, ns;
	logic [cddir_pkg::BS_W-1:0]      bs_c;
	logic [cddir_pkg::NS_W-1:0]      ns_c;
	logic [cddir_pkg::DV_W:0]        pos_full;
	cddir_pkg::div_req_t             dreq;
	cddir_pkg::div_rsp_t             drsp;

	always_comb begin
		if (bs_reg == '0)
			bs_c = cddir_pkg::BS_W'(1);
		else if (32'(bs_reg) > MAX_BLOCK)
			bs_c = cddir_pkg::BS_W'(MAX_BLOCK);
		else
			bs_c = bs_reg;
		if (ns_reg == '0)
			ns_c = cddir_pkg::NS_W'(1);
		else if (32'(ns_reg) > MAX_SLOTS)
			ns_c = cddir_pkg::NS_W'(MAX_SLOTS);
		else
			ns_c = ns_reg;
	end

	assign epo = (epo_reg == '0) ? cddir_pkg::DV_W'(1) : cddir_pkg::DV_W'(epo_reg);
	assign bs  = cddir_pkg::DV_W'(bs_c);
	assign ns  = cddir_pkg::DV_W'(ns_c);

	always_comb begin
		dreq.start    = start_q;
		dreq.dividend = idx_q;
		dreq.divisor  = epo;
		unique case (phase_q)
			PH_OWN: begin
				dreq.dividend = idx_q;
				dreq.divisor  = epo;
			end
			PH_TAG: begin
				dreq.dividend = idx_q;
				dreq.divisor  = bs;
			end
			PH_BLK: begin
				dreq.dividend = in_owner_q;
				dreq.divisor  = bs;
			end
			PH_SLOT: begin
				dreq.dividend = tag_q;
				dreq.divisor  = ns;
			end
			default: begin
				dreq.dividend = idx_q;
				dreq.divisor  = epo;
			end
		endcase
	end

	cddir_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			phase_q <= PH_OWN;
			start_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			unique case (state_q)
				F_IDLE: begin
					if (push && !busy) begin
						state_q <= F_DIV;
						phase_q <= PH_OWN;
						start_q <= 1'b1;
					end
				end
				F_DIV: begin
					if (drsp.done) begin
						if (phase_q == PH_SLOT) begin
							state_q <= F_PUSH;
						end else begin
							phase_q <= phase_q + cddir_pkg::PH_W'(1);
							start_q <= 1'b1;
						end
					end
				end
				F_PUSH: begin
					if (!q_full)
						state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && push && !busy)
			idx_q <= element_index;
		if (state_q == F_DIV && drsp.done) begin
			case (phase_q)
				PH_OWN: begin
					owner_q    <= drsp.quot;
					in_owner_q <= cddir_pkg::IW'(drsp.rem);
				end
				PH_TAG: begin
					tag_q    <= drsp.quot;
					offset_q <= cddir_pkg::BS_W'(drsp.rem);
				end
				PH_BLK:  rblk_q <= cddir_pkg::BS_W'(drsp.rem);
				PH_SLOT: slot_q <= cddir_pkg::SLOT_W'(drsp.rem);
				default: ;
			endcase
		end
	end

	assign pos_full = (cddir_pkg::DV_W + 1)'(slot_q) * (cddir_pkg::DV_W + 1)'(bs_c)
		+ (cddir_pkg::DV_W + 1)'(offset_q);

	assign busy   = (state_q != F_IDLE);
	assign q_push = (state_q == F_PUSH) && !q_full;

	always_comb begin
		q_item            = '0;
		q_item.owner      = owner_q;
		q_item.in_owner   = in_owner_q;
		q_item.blk_start  = in_owner_q - cddir_pkg::IW'(rblk_q);
		q_item.tag        = tag_q;
		q_item.pos        = pos_full[cddir_pkg::IW-1:0];
		q_item.slot       = slot_q;
		q_item.seen_idx   = cddir_pkg::SEEN_W'(32'(tag_q) % ARRAY_SIZE);
		q_item.owned_here = (owner_q == cddir_pkg::IW'(rank_reg));
	end

endmodule

[rtl/core/cddir_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cddir_back
// Looks up the slot and fetch stores, updates them and the counters.
// ----------------------------------------------------------------------------
module cddir_back #(
	parameter int ARRAY_SIZE = 16384,
	parameter int MAX_SLOTS  = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_empty,
	input  cddir_pkg::item_t            q_item,
	output logic                        q_pop,
	output cddir_pkg::back_stat_t       stat,
	input  logic                        pop,
	output logic                        empty,
	output logic [1:0]                  outcome,
	output logic [cddir_pkg::IW-1:0]    cache_position,
	output logic [cddir_pkg::IW-1:0]    owner_number,
	output logic [cddir_pkg::IW-1:0]    index_in_owner,
	output logic [cddir_pkg::IW-1:0]    owner_block_start,
	output logic [cddir_pkg::IW-1:0]    block_tag,
	output logic                        evicted,
	output logic                        fetched_before,
	output logic [cddir_pkg::CNT_W-1:0] hit_total,
	output logic [cddir_pkg::CNT_W-1:0] miss_total,
	output logic [cddir_pkg::CNT_W-1:0] eviction_total,
	output logic [cddir_pkg::CNT_W-1:0] refetch_total
);
	localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int AW = $clog2(ARRAY_SIZE);

	typedef enum logic [2:0] {
		B_CLR  = 3'b001,
		B_IDLE = 3'b010,
		B_EVAL = 3'b100
	} bstate_t;

	bstate_t                        state_q;
	logic [AW-1:0]                  clr_q;
	logic [MAX_SLOTS-1:0]           slot_valid_q;
	logic [cddir_pkg::IW-1:0]       slot_tag_mem [MAX_SLOTS];
	logic                           tag_seen_mem [ARRAY_SIZE];
	logic [cddir_pkg::IW-1:0]       rd_tag_q;
	logic                           rd_seen_q;
	cddir_pkg::item_t               cur_q;
	logic                           out_v_q;
	logic [cddir_pkg::CNT_W-1:0]    hits_q, misses_q, evict_q, refetch_q;
	logic [SW-1:0]                  sidx;
	logic [AW-1:0]                  aidx;
	logic                           vld, cache_hit, miss, fire;
	logic                           seen_we;
	logic [AW-1:0]                  seen_wa;
	logic [cddir_pkg::CNT_W-1:0]    hits_n, misses_n, evict_n, refetch_n;

	assign sidx      = cur_q.slot[SW-1:0];
	assign aidx      = cur_q.seen_idx[AW-1:0];
	assign vld       = slot_valid_q[sidx];
	assign cache_hit = vld && (rd_tag_q == cur_q.tag);
	assign miss      = !cache_hit && !cur_q.owned_here;
	assign fire      = (state_q == B_EVAL) && (!out_v_q || pop);

	assign hits_n    = miss ? hits_q : cddir_pkg::sat_inc(hits_q);
	assign misses_n  = miss ? cddir_pkg::sat_inc(misses_q) : misses_q;
	assign evict_n   = (miss && vld) ? cddir_pkg::sat_inc(evict_q) : evict_q;
	assign refetch_n = (miss && rd_seen_q) ? cddir_pkg::sat_inc(refetch_q) : refetch_q;

	assign q_pop         = (state_q == B_IDLE) && !q_empty;
	assign stat.clearing = (state_q == B_CLR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= B_CLR;
			clr_q        <= '0;
			slot_valid_q <= '0;
			out_v_q      <= 1'b0;
			hits_q       <= '0;
			misses_q     <= '0;
			evict_q      <= '0;
			refetch_q    <= '0;
		end else begin
			if (fire)
				out_v_q <= 1'b1;
			else if (pop)
				out_v_q <= 1'b0;
			unique case (state_q)
				B_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(ARRAY_SIZE - 1))
						state_q <= B_IDLE;
				end
				B_IDLE: begin
					if (!q_empty)
						state_q <= B_EVAL;
				end
				B_EVAL: begin
					if (fire) begin
						state_q   <= B_IDLE;
						hits_q    <= hits_n;
						misses_q  <= misses_n;
						evict_q   <= evict_n;
						refetch_q <= refetch_n;
						if (miss)
							slot_valid_q[sidx] <= 1'b1;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// The fetch map has a single write port: the clearing pass and the updates share it.
	assign seen_we = (state_q == B_CLR) || (fire && miss && !rd_seen_q);
	assign seen_wa = (state_q == B_CLR) ? clr_q : aidx;

	always_ff @(posedge clk) begin
		if (seen_we)
			tag_seen_mem[seen_wa] <= (state_q != B_CLR);
		if (q_pop)
			rd_seen_q <= tag_seen_mem[q_item.seen_idx[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (fire && miss)
			slot_tag_mem[sidx] <= cur_q.tag;
		if (q_pop)
			rd_tag_q <= slot_tag_mem[q_item.slot[SW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			cur_q <= q_item;
		if (fire) begin
			outcome           <= cache_hit ? cddir_pkg::OUT_CACHE_HIT :
				(miss ? cddir_pkg::OUT_MISS : cddir_pkg::OUT_LOCAL_HIT);
			cache_position    <= cur_q.pos;
			owner_number      <= cur_q.owner;
			index_in_owner    <= cur_q.in_owner;
			owner_block_start <= cur_q.blk_start;
			block_tag         <= cur_q.tag;
			evicted           <= miss && vld;
			fetched_before    <= miss && rd_seen_q;
			hit_total         <= hits_n;
			miss_total        <= misses_n;
			eviction_total    <= evict_n;
			refetch_total     <= refetch_n;
		end
	end

	assign empty = !out_v_q;

	a_miss_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && miss) |=> slot_valid_q[$past(sidx)])
		else $error("miss did not mark its slot valid");

	a_hits_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		hits_q >= $past(hits_q))
		else $error("hit counter went backwards");

	a_no_work_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_CLR) |-> (!out_v_q && !q_pop))
		else $error("request handled during clearing pass");

endmodule
